### hw/rtl/llqp_pkg.sv
// Shared types and constants for the least-loaded queue picker.
// No dependencies; every other file of the block uses this package.
package llqp_pkg;

  localparam int unsigned WORKERS = 8;
  localparam int unsigned WIDX_W  = $clog2(WORKERS);
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned DEPTH_W = 16;

  localparam logic [CNT_W-1:0] ActiveReset = CNT_W'(WORKERS);

  typedef logic [DEPTH_W-1:0] depth_t;
  typedef depth_t [WORKERS-1:0] depth_arr_t;

  typedef struct packed {
    logic [WIDX_W-1:0] worker;
    logic              empty;
    logic [WIDX_W-1:0] next_start;
  } pick_res_t;

endpackage

### hw/rtl/llqp_req_if.sv
// Request channel of the picker: valid/ready plus the eight queue occupancies.
// Depends on llqp_pkg.
interface llqp_req_if;
  logic                         valid;
  logic                         ready;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w0;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w1;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w2;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w3;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w4;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w5;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w6;
  logic [llqp_pkg::DEPTH_W-1:0] depth_w7;

  modport source (output valid, depth_w0, depth_w1, depth_w2, depth_w3,
                  depth_w4, depth_w5, depth_w6, depth_w7, input ready);
  modport sink   (input valid, depth_w0, depth_w1, depth_w2, depth_w3,
                  depth_w4, depth_w5, depth_w6, depth_w7, output ready);
endinterface

### hw/rtl/llqp_rsp_if.sv
// Response channel of the picker: valid/ready plus the chosen worker.
// Depends on llqp_pkg.
interface llqp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [llqp_pkg::WIDX_W-1:0] chosen_worker;
  logic                        found_empty;

  modport source (output valid, chosen_worker, found_empty, input ready);
  modport sink   (input valid, chosen_worker, found_empty, output ready);
endinterface

### hw/rtl/llqp_pick.sv
// Combinational pick: rotated rank per worker and a three-level minimum tree.
// Depends on llqp_pkg.
module llqp_pick (
  input  llqp_pkg::depth_arr_t           depth_i,
  input  logic [llqp_pkg::CNT_W-1:0]     count_i,
  input  logic [llqp_pkg::WIDX_W-1:0]    start_i,
  output llqp_pkg::pick_res_t            res_o
);
  import llqp_pkg::*;

  typedef struct packed {
    logic              invalid;
    depth_t            depth;
    logic [WIDX_W-1:0] rank;
    logic [WIDX_W-1:0] idx;
  } cand_t;

  localparam int unsigned KeyW = 1 + DEPTH_W + WIDX_W;

  cand_t             lvl0 [WORKERS];
  cand_t             lvl1 [WORKERS/2];
  cand_t             lvl2 [WORKERS/4];
  cand_t             best;
  logic [CNT_W-1:0]  start_eff;
  logic [CNT_W-1:0]  widx;
  logic [CNT_W-1:0]  rank_w;
  logic [CNT_W-1:0]  next_w;

  function automatic cand_t min_cand(cand_t a, cand_t b);
    logic [KeyW-1:0] ka;
    logic [KeyW-1:0] kb;
    ka = {a.invalid, a.depth, a.rank};
    kb = {b.invalid, b.depth, b.rank};
    return (kb < ka) ? b : a;
  endfunction

  always_comb begin
    start_eff = (CNT_W'(start_i) >= count_i) ? '0 : CNT_W'(start_i);
    widx      = '0;
    rank_w    = '0;
    for (int w = 0; w < WORKERS; w++) begin
      widx   = CNT_W'(w);
      rank_w = (widx >= start_eff) ? (widx - start_eff) : (widx + count_i - start_eff);
      lvl0[w].invalid = (widx >= count_i);
      lvl0[w].depth   = depth_i[w];
      lvl0[w].rank    = rank_w[WIDX_W-1:0];
      lvl0[w].idx     = widx[WIDX_W-1:0];
    end
    for (int i = 0; i < WORKERS/2; i++) begin
      lvl1[i] = min_cand(lvl0[2*i], lvl0[2*i+1]);
    end
    for (int i = 0; i < WORKERS/4; i++) begin
      lvl2[i] = min_cand(lvl1[2*i], lvl1[2*i+1]);
    end
    best   = min_cand(lvl2[0], lvl2[1]);
    next_w = CNT_W'(best.idx) + CNT_W'(1);
    res_o.worker     = best.idx;
    res_o.empty      = (best.depth == '0);
    res_o.next_start = (next_w >= count_i) ? '0 : next_w[WIDX_W-1:0];
  end

endmodule

### hw/rtl/least_loaded_queue_picker.sv
// Least-loaded queue picker: picks one of up to eight worker queues per request.
// Depends on llqp_pkg, llqp_req_if, llqp_rsp_if and llqp_pick.
//
// Requests arrive on req_i with the occupancy of every worker queue. Each one
// yields exactly one response on rsp_o: the chosen worker and whether its queue
// was empty. The scan runs over the active workers in rotating order from the
// worker after the previous pick; the first empty queue wins, otherwise the
// least occupied one, with ties going to the one met first.
// A request is registered on acceptance and its pick is computed from that
// register into the response register, which loads as soon as it is empty
// or its response is taken. One request is taken per cycle while the receiver
// keeps up; the rate is set by the single pass through the minimum tree, which
// also updates the scan start that the next request uses.
// When the receiver stalls, the response register holds and the request
// register still takes one more request, after which req_i.ready drops.
// cfg_we_i writes the active worker count; zero acts as one and values above
// eight act as eight. Write it only while no request is in flight.
// Reset empties both registers, sets the count to eight and the scan start to
// worker zero.
module least_loaded_queue_picker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [llqp_pkg::CNT_W-1:0] cfg_wdata_i,
  llqp_req_if.sink                   req_i,
  llqp_rsp_if.source                 rsp_o
);
  import llqp_pkg::*;

  logic              s1_valid_q;
  depth_arr_t        s1_depth_q;
  logic              s2_valid_q;
  logic [WIDX_W-1:0] s2_worker_q;
  logic              s2_empty_q;
  logic [WIDX_W-1:0] scan_start_q;
  logic [WIDX_W-1:0] scan_start_d;
  logic [CNT_W-1:0]  active_q;
  logic [CNT_W-1:0]  count;
  logic              s2_load;
  logic              req_acc;
  pick_res_t         pick;

  assign count = (active_q == '0) ? CNT_W'(1) :
                 (active_q > CNT_W'(WORKERS)) ? CNT_W'(WORKERS) : active_q;

  assign s2_load     = s1_valid_q && (!s2_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s2_load;
  assign req_acc     = req_i.valid && req_i.ready;
  assign scan_start_d = s2_load ? pick.next_start : scan_start_q;

  llqp_pick u_pick (
    .depth_i (s1_depth_q),
    .count_i (count),
    .start_i (scan_start_q),
    .res_o   (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      scan_start_q <= '0;
      active_q     <= ActiveReset;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        s2_valid_q <= 1'b0;
      end
      scan_start_q <= scan_start_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_depth_q <= {req_i.depth_w7, req_i.depth_w6, req_i.depth_w5, req_i.depth_w4,
                     req_i.depth_w3, req_i.depth_w2, req_i.depth_w1, req_i.depth_w0};
    end
    if (s2_load) begin
      s2_worker_q <= pick.worker;
      s2_empty_q  <= pick.empty;
    end
  end

  assign rsp_o.valid         = s2_valid_q;
  assign rsp_o.chosen_worker = s2_worker_q;
  assign rsp_o.found_empty   = s2_empty_q;

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |-> (CNT_W'(pick.worker) < count))
    else $error("Picked worker is outside the active range.");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |-> (pick.empty == (s1_depth_q[pick.worker] == '0)))
    else $error("Empty flag does not match the chosen queue.");

  a_start_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> (CNT_W'(scan_start_q) < $past(count)))
    else $error("Scan start moved outside the active range.");

  a_start_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_load |=> $stable(scan_start_q))
    else $error("Scan start changed without a pick.");

endmodule

### bench/tb.sv
// Self-checking testbench for least_loaded_queue_picker with request and response channels.
// It predicts each pick in the testbench, queues the expected picks and compares every response.
// Depends on llqp_pkg, llqp_req_if, llqp_rsp_if and the picker RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llqp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RSP_HOLD_CYCLES = 48;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned CALM_ITEMS = 130;

  typedef struct packed {
    logic [WIDX_W-1:0] worker;
    logic              empty;
  } pick_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  llqp_req_if req_if ();
  llqp_rsp_if rsp_if ();

  least_loaded_queue_picker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic [CNT_W-1:0]  worker_count_reg = ActiveReset;
  logic [WIDX_W-1:0] next_scan = '0;
  pick_t             pending_picks[$];
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  bit                quiet = 1'b0;
  bit                hold_rsp = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    if (fail_count <= 100) begin
      $display("MISMATCH at cycle %0d: %s, got %0d, expected %0d", cycle_count, what, got, want);
    end
  endtask

  // The scan covers the active workers in rotating order from the stored start.
  function automatic pick_t predict_pick(depth_arr_t d);
    int unsigned n;
    int unsigned start;
    int unsigned w;
    int unsigned best_depth;
    pick_t p;
    n = (worker_count_reg == '0) ? 1 : worker_count_reg;
    if (n > WORKERS) n = WORKERS;
    start = (next_scan < n) ? next_scan : 0;
    p.worker = '0;
    p.empty = 1'b0;
    best_depth = 32'h1_0000;
    for (int unsigned k = 0; k < n; k++) begin
      w = (start + k) % n;
      if (d[w] == '0) begin
        p.worker = WIDX_W'(w);
        p.empty = 1'b1;
        break;
      end
      if (d[w] < best_depth) begin
        p.worker = WIDX_W'(w);
        best_depth = d[w];
      end
    end
    next_scan = WIDX_W'((p.worker + 1) % n);
    return p;
  endfunction

  function automatic depth_arr_t random_depths();
    depth_arr_t d;
    int unsigned style;
    style = $urandom_range(0, 4);
    for (int i = 0; i < WORKERS; i++) begin
      case (style)
        0: d[i] = DEPTH_W'($urandom);
        1: d[i] = DEPTH_W'($urandom_range(0, 3));
        2: d[i] = ($urandom_range(0, 3) == 0) ? '0 : DEPTH_W'($urandom);
        3: d[i] = DEPTH_W'($urandom_range(1, 4));
        default: d[i] = DEPTH_W'(16'hFFFF - $urandom_range(0, 2));
      endcase
    end
    return d;
  endfunction

  function automatic depth_arr_t uniform_depths(depth_t value);
    depth_arr_t d;
    for (int i = 0; i < WORKERS; i++) d[i] = value;
    return d;
  endfunction

  task automatic send_request(depth_arr_t d);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.depth_w0 <= d[0];
    req_if.depth_w1 <= d[1];
    req_if.depth_w2 <= d[2];
    req_if.depth_w3 <= d[3];
    req_if.depth_w4 <= d[4];
    req_if.depth_w5 <= d[5];
    req_if.depth_w6 <= d[6];
    req_if.depth_w7 <= d[7];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_picks.push_back(predict_pick(d));
  endtask

  task automatic wait_all_picked();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_picks.size() != 0);
  endtask

  task automatic write_worker_count(logic [CNT_W-1:0] value);
    wait_all_picked();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    worker_count_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    depth_arr_t d;
    send_request(uniform_depths(16'hFFFF));
    send_request(uniform_depths(16'hFFFF));
    send_request(uniform_depths(16'h0000));
    d = uniform_depths(16'd100);
    d[5] = 16'd3;
    send_request(d);
  endtask

  task automatic test_field_extremes();
    depth_arr_t d;
    for (int i = 0; i < WORKERS; i++) d[i] = (i % 2 == 0) ? 16'hAAAA : 16'h5555;
    send_request(d);
    for (int i = 0; i < WORKERS; i++) d[i] = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
    send_request(d);
    d = uniform_depths(16'hFFFF);
    d[7] = 16'hFFFE;
    send_request(d);
    send_request(uniform_depths(16'h0001));
  endtask

  task automatic test_worker_count_limits();
    depth_arr_t d;
    write_worker_count(4'd0);
    send_request(uniform_depths(16'hFFFF));
    d = uniform_depths(16'hFFFF);
    d[0] = '0;
    send_request(d);
    write_worker_count(4'd1);
    send_request(uniform_depths(16'h0000));
    send_request(uniform_depths(16'hFFFF));
    write_worker_count(4'd15);
    send_request(uniform_depths(16'hFFFF));
    send_request(uniform_depths(16'hFFFF));
    write_worker_count(4'd9);
    send_request(uniform_depths(16'hFFFF));
  endtask

  task automatic test_stale_scan_start();
    depth_arr_t d;
    write_worker_count(4'd8);
    d = uniform_depths(16'hFFFF);
    d[6] = '0;
    send_request(d);
    write_worker_count(4'd4);
    send_request(uniform_depths(16'hFFFF));
    d = uniform_depths(16'hFFFF);
    d[3] = 16'd10;
    send_request(d);
  endtask

  task automatic test_backpressure();
    bit saved_quiet;
    wait_all_picked();
    saved_quiet = quiet;
    quiet = 1'b1;
    hold_rsp = 1'b1;
    repeat (12) send_request(random_depths());
    quiet = saved_quiet;
    wait_all_picked();
  endtask

  task automatic run_random_phase(logic [CNT_W-1:0] count, int unsigned items);
    write_worker_count(count);
    repeat (items) send_request(random_depths());
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] counts[12] = '{4'd8, 4'd1, 4'd0, 4'd5, 4'd15, 4'd2,
                                     4'd9, 4'd7, 4'd3, 4'd4, 4'd6, 4'd8};
    foreach (counts[i]) begin
      run_random_phase(counts[i], PHASE_ITEMS);
      if (i == 5) test_backpressure();
    end
    quiet = 1'b1;
    run_random_phase(4'd8, CALM_ITEMS);
  endtask

  initial begin : rsp_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
        rsp_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_picks.size() == 0) begin
        report_mismatch("response with no request pending", rsp_if.chosen_worker, -1);
      end else begin
        want = pending_picks.pop_front();
        if (rsp_if.chosen_worker !== want.worker) begin
          report_mismatch("chosen_worker", rsp_if.chosen_worker, want.worker);
        end
        if (rsp_if.found_empty !== want.empty) begin
          report_mismatch("found_empty", rsp_if.found_empty, want.empty);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    req_if.valid    <= 1'b0;
    req_if.depth_w0 <= '0;
    req_if.depth_w1 <= '0;
    req_if.depth_w2 <= '0;
    req_if.depth_w3 <= '0;
    req_if.depth_w4 <= '0;
    req_if.depth_w5 <= '0;
    req_if.depth_w6 <= '0;
    req_if.depth_w7 <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_field_extremes();
    test_worker_count_limits();
    test_stale_scan_start();
    test_random_traffic();

    wait_all_picked();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
